// ----- rtl/mi4_pkg.sv -----
// mi4_pkg: shared widths, types and index tables for the 4x4 matrix inverse unit.
// No dependencies; used by mi4_datapath, mi4_ctrl and the top level.
package mi4_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned ElemW     = 32;
  localparam int unsigned NumElem   = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned MinorW    = 2 * ElemW + 1;          // 2x2 minor
  localparam int unsigned CofW      = 3 * ElemW + 3;          // cofactor
  localparam int unsigned DetW      = 4 * ElemW + 4;          // determinant
  localparam int unsigned NumW      = CofW + 2 * FracBits + 2; // shifted numerator
  localparam int unsigned QuoW      = NumW;
  localparam int unsigned QCntW     = $clog2(QuoW + 1);
  localparam int unsigned TDataInW  = 32;
  localparam int unsigned TDataOutW = 40;
  localparam int unsigned LimbW     = 32;                     // multiplier limb
  localparam int unsigned ProdW     = 4 * LimbW;              // product magnitude

  // Product steps 0..3 accumulate limb products; this step applies the term.
  localparam logic [2:0]  MulApply  = 3'd4;

  typedef logic signed [ElemW-1:0]  elem_t;
  typedef logic signed [MinorW-1:0] minor_t;
  typedef logic signed [CofW-1:0]   cof_t;
  typedef logic signed [DetW-1:0]   det_t;

  // Datapath operations, issued by the controller.
  typedef enum logic [2:0] {
    OpNone,
    OpMinor,     // minor[sel] = a*b - c*d, two product steps
    OpDet,       // det += +/- minor*minor
    OpCof,       // cof += +/- elem*minor
    OpDivStart,  // load divider from cof and det
    OpDivStep    // one restoring divide bit
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [3:0]         sel;   // minor, det term or cofactor term index
    logic [IdxW-1:0]    cof_idx;
    logic               phase; // first or second product of a step
    logic [2:0]         step;  // limb product step of a det or cofactor term
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } stat_t;

  // Minor table: a*b - c*d, element indexes.
  function automatic logic [15:0] minor_tab(input logic [3:0] i);
    logic [15:0] r;
    begin
      unique case (i)
        4'd0:    r = {4'd0, 4'd5, 4'd4, 4'd1};
        4'd1:    r = {4'd0, 4'd6, 4'd4, 4'd2};
        4'd2:    r = {4'd0, 4'd7, 4'd4, 4'd3};
        4'd3:    r = {4'd1, 4'd6, 4'd5, 4'd2};
        4'd4:    r = {4'd1, 4'd7, 4'd5, 4'd3};
        4'd5:    r = {4'd2, 4'd7, 4'd6, 4'd3};
        4'd6:    r = {4'd8, 4'd13, 4'd12, 4'd9};
        4'd7:    r = {4'd8, 4'd14, 4'd12, 4'd10};
        4'd8:    r = {4'd8, 4'd15, 4'd12, 4'd11};
        4'd9:    r = {4'd9, 4'd14, 4'd13, 4'd10};
        4'd10:   r = {4'd9, 4'd15, 4'd13, 4'd11};
        default: r = {4'd10, 4'd15, 4'd14, 4'd11};
      endcase
      return r;
    end
  endfunction

  // Cofactor table: negate, then (element, minor) x3 with signs + - +.
  function automatic logic [24:0] cof_tab(input logic [3:0] i);
    logic [24:0] r;
    begin
      unique case (i)
        4'd0:    r = {1'b0, 4'd5, 4'd11, 4'd6, 4'd10, 4'd7, 4'd9};
        4'd1:    r = {1'b1, 4'd1, 4'd11, 4'd2, 4'd10, 4'd3, 4'd9};
        4'd2:    r = {1'b0, 4'd13, 4'd5, 4'd14, 4'd4, 4'd15, 4'd3};
        4'd3:    r = {1'b1, 4'd9, 4'd5, 4'd10, 4'd4, 4'd11, 4'd3};
        4'd4:    r = {1'b1, 4'd4, 4'd11, 4'd6, 4'd8, 4'd7, 4'd7};
        4'd5:    r = {1'b0, 4'd0, 4'd11, 4'd2, 4'd8, 4'd3, 4'd7};
        4'd6:    r = {1'b1, 4'd12, 4'd5, 4'd14, 4'd2, 4'd15, 4'd1};
        4'd7:    r = {1'b0, 4'd8, 4'd5, 4'd10, 4'd2, 4'd11, 4'd1};
        4'd8:    r = {1'b0, 4'd4, 4'd10, 4'd5, 4'd8, 4'd7, 4'd6};
        4'd9:    r = {1'b1, 4'd0, 4'd10, 4'd1, 4'd8, 4'd3, 4'd6};
        4'd10:   r = {1'b0, 4'd12, 4'd4, 4'd13, 4'd2, 4'd15, 4'd0};
        4'd11:   r = {1'b1, 4'd8, 4'd4, 4'd9, 4'd2, 4'd11, 4'd0};
        4'd12:   r = {1'b1, 4'd4, 4'd9, 4'd5, 4'd7, 4'd6, 4'd6};
        4'd13:   r = {1'b0, 4'd0, 4'd9, 4'd1, 4'd7, 4'd2, 4'd6};
        4'd14:   r = {1'b1, 4'd12, 4'd3, 4'd13, 4'd1, 4'd14, 4'd0};
        default: r = {1'b0, 4'd8, 4'd3, 4'd9, 4'd1, 4'd10, 4'd0};
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/mi4_datapath.sv -----
// mi4_datapath: element store, minor/determinant/cofactor accumulation and
// a bit-serial restoring divider. Depends on mi4_pkg.
module mi4_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [3:0]           wr_idx_i,
  input  mi4_pkg::elem_t       wr_data_i,
  input  mi4_pkg::cmd_t        cmd_i,
  output mi4_pkg::stat_t       stat_o,
  output mi4_pkg::elem_t       result_o
);

  mi4_pkg::elem_t  elem_q [mi4_pkg::NumElem];
  mi4_pkg::minor_t minor_q [12];
  mi4_pkg::det_t   det_q;
  mi4_pkg::cof_t   cof_q;
  logic signed [mi4_pkg::MinorW-1:0] prod_lo_q;
  logic [mi4_pkg::ProdW-1:0] mag_q;

  logic [mi4_pkg::NumW-1:0] rem_q, num_q;
  logic [mi4_pkg::DetW-1:0] den_q;
  logic [mi4_pkg::QuoW-1:0] quo_q;
  logic [mi4_pkg::QCntW-1:0] cnt_q;
  logic neg_q;

  logic [15:0] mt;
  logic [24:0] ct;
  logic [3:0]  ea, eb, mi;
  logic        sub_term, neg_cof;
  logic signed [2*mi4_pkg::ElemW-1:0] ee_prod;
  logic [3:0]  ma, mb;
  logic        det_sub;
  mi4_pkg::minor_t mn_a, mn_b;
  logic [mi4_pkg::MinorW-1:0] abs_a, abs_b;
  logic        prod_neg;
  logic [mi4_pkg::LimbW-1:0] limb_a, limb_b;
  logic [2*mi4_pkg::LimbW-1:0] limb_prod;
  logic [mi4_pkg::ProdW-1:0] limb_sh;
  logic [mi4_pkg::DetW-1:0] det_term;
  logic [mi4_pkg::CofW-1:0] cof_term;
  logic        det_minus, cof_minus;
  logic [mi4_pkg::NumW-1:0] rem_sh, rem_diff;
  logic [mi4_pkg::NumW:0]   rem_try;
  logic [mi4_pkg::DetW-1:0] det_abs;
  logic [mi4_pkg::CofW-1:0] cof_abs;
  logic [mi4_pkg::QuoW-1:0] quo_sat;
  logic [mi4_pkg::ElemW-1:0] max_pos;

  assign mt = mi4_pkg::minor_tab(cmd_i.sel);
  assign ct = mi4_pkg::cof_tab(cmd_i.cof_idx);
  assign neg_cof = ct[24];

  // Pick element pair for a minor step; pick element/minor for a cofactor term.
  always_comb begin
    ea = cmd_i.phase ? mt[7:4] : mt[15:12];
    eb = cmd_i.phase ? mt[3:0] : mt[11:8];
    unique case (cmd_i.sel[1:0])
      2'd0:    begin eb = ct[23:20]; mi = ct[19:16]; end
      2'd1:    begin eb = ct[15:12]; mi = ct[11:8];  end
      default: begin eb = ct[7:4];   mi = ct[3:0];   end
    endcase
    if (cmd_i.op == mi4_pkg::OpMinor) begin
      eb = cmd_i.phase ? mt[3:0] : mt[11:8];
    end
    sub_term = (cmd_i.sel[1:0] == 2'd1) ^ neg_cof;
  end

  // Determinant terms: (minor pair, subtract)
  always_comb begin
    unique case (cmd_i.sel[2:0])
      3'd0:    begin ma = 4'd0; mb = 4'd11; det_sub = 1'b0; end
      3'd1:    begin ma = 4'd1; mb = 4'd10; det_sub = 1'b1; end
      3'd2:    begin ma = 4'd2; mb = 4'd9;  det_sub = 1'b0; end
      3'd3:    begin ma = 4'd3; mb = 4'd8;  det_sub = 1'b0; end
      3'd4:    begin ma = 4'd4; mb = 4'd7;  det_sub = 1'b1; end
      default: begin ma = 4'd5; mb = 4'd6;  det_sub = 1'b0; end
    endcase
  end

  assign ee_prod = elem_q[ea] * elem_q[eb];

  // Wide products as sign and magnitude; magnitudes fit in two limbs.
  always_comb begin
    mn_a     = (cmd_i.op == mi4_pkg::OpDet) ? minor_q[ma] : mi4_pkg::MinorW'(elem_q[eb]);
    mn_b     = (cmd_i.op == mi4_pkg::OpDet) ? minor_q[mb] : minor_q[mi];
    abs_a    = mn_a[mi4_pkg::MinorW-1] ? -mn_a : mn_a;
    abs_b    = mn_b[mi4_pkg::MinorW-1] ? -mn_b : mn_b;
    prod_neg = mn_a[mi4_pkg::MinorW-1] ^ mn_b[mi4_pkg::MinorW-1];
    limb_a   = cmd_i.step[1] ? abs_a[2*mi4_pkg::LimbW-1:mi4_pkg::LimbW]
                             : abs_a[mi4_pkg::LimbW-1:0];
    limb_b   = cmd_i.step[0] ? abs_b[2*mi4_pkg::LimbW-1:mi4_pkg::LimbW]
                             : abs_b[mi4_pkg::LimbW-1:0];
    limb_prod = (2*mi4_pkg::LimbW)'(limb_a) * (2*mi4_pkg::LimbW)'(limb_b);
    case (cmd_i.step[1:0])
      2'd0:    limb_sh = mi4_pkg::ProdW'(limb_prod);
      2'd3:    limb_sh = mi4_pkg::ProdW'(limb_prod) << (2 * mi4_pkg::LimbW);
      default: limb_sh = mi4_pkg::ProdW'(limb_prod) << mi4_pkg::LimbW;
    endcase
  end

  assign det_term  = mi4_pkg::DetW'(mag_q);
  assign cof_term  = mag_q[mi4_pkg::CofW-1:0];
  assign det_minus = det_sub ^ prod_neg;
  assign cof_minus = sub_term ^ prod_neg;

  assign det_abs = det_q[mi4_pkg::DetW-1] ? mi4_pkg::DetW'(-det_q) : mi4_pkg::DetW'(det_q);
  assign cof_abs = cof_q[mi4_pkg::CofW-1] ? mi4_pkg::CofW'(-cof_q) : mi4_pkg::CofW'(cof_q);

  assign rem_sh   = {rem_q[mi4_pkg::NumW-2:0], num_q[mi4_pkg::NumW-1]};
  assign rem_try  = {1'b0, rem_sh} - {mi4_pkg::NumW'(den_q), 1'b0};
  assign rem_diff = rem_sh - (mi4_pkg::NumW'(den_q) << 1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      elem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minor_q   <= '{default: '0};
      prod_lo_q <= '0;
      mag_q     <= '0;
      det_q     <= '0;
      cof_q     <= '0;
      num_q     <= '0;
      den_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      neg_q     <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        mi4_pkg::OpMinor: begin
          if (!cmd_i.phase) begin
            prod_lo_q <= mi4_pkg::MinorW'(ee_prod);
          end else begin
            minor_q[cmd_i.sel] <= prod_lo_q - mi4_pkg::MinorW'(ee_prod);
          end
        end
        mi4_pkg::OpDet: begin
          if (cmd_i.step == mi4_pkg::MulApply) begin
            if (cmd_i.sel[2:0] == 3'd0) begin
              det_q <= det_minus ? -det_term : det_term;
            end else if (det_minus) begin
              det_q <= det_q - det_term;
            end else begin
              det_q <= det_q + det_term;
            end
          end else begin
            mag_q <= (cmd_i.step == 3'd0) ? limb_sh : mag_q + limb_sh;
          end
        end
        mi4_pkg::OpCof: begin
          if (cmd_i.step == mi4_pkg::MulApply) begin
            if (cmd_i.sel[1:0] == 2'd0) begin
              cof_q <= cof_minus ? -cof_term : cof_term;
            end else if (cof_minus) begin
              cof_q <= cof_q - cof_term;
            end else begin
              cof_q <= cof_q + cof_term;
            end
          end else begin
            mag_q <= (cmd_i.step == 3'd0) ? limb_sh : mag_q + limb_sh;
          end
        end
        mi4_pkg::OpDivStart: begin
          // numerator = 2*|cof|*2^(2F) + |det|, divisor = 2*|det|
          num_q <= (mi4_pkg::NumW'(cof_abs) << (2 * mi4_pkg::FracBits + 1))
                   + mi4_pkg::NumW'(det_abs);
          den_q <= det_abs;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= '0;
          neg_q <= cof_q[mi4_pkg::CofW-1] ^ det_q[mi4_pkg::DetW-1];
        end
        mi4_pkg::OpDivStep: begin
          num_q <= num_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (!rem_try[mi4_pkg::NumW]) begin
            rem_q <= rem_diff;
            quo_q <= {quo_q[mi4_pkg::QuoW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[mi4_pkg::QuoW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  // Saturate magnitude, then apply sign.
  assign max_pos = {1'b0, {(mi4_pkg::ElemW-1){1'b1}}};
  always_comb begin
    quo_sat = quo_q;
    if (!neg_q && quo_q > mi4_pkg::QuoW'(max_pos)) begin
      quo_sat = mi4_pkg::QuoW'(max_pos);
    end else if (neg_q && quo_q > mi4_pkg::QuoW'(max_pos) + 1'b1) begin
      quo_sat = mi4_pkg::QuoW'(max_pos) + 1'b1;
    end
    result_o = neg_q ? mi4_pkg::ElemW'(-quo_sat) : mi4_pkg::ElemW'(quo_sat);
  end

  assign stat_o.det_zero = (det_q == '0);
  assign stat_o.div_done = (cnt_q == mi4_pkg::QCntW'(mi4_pkg::QuoW));

endmodule

// ----- rtl/mi4_ctrl.sv -----
// mi4_ctrl: load counter and sequencer that issues datapath operations and
// drives the output register. Depends on mi4_pkg.
module mi4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 wr_en_o,
  output logic [3:0]           wr_idx_o,
  output mi4_pkg::cmd_t        cmd_o,
  input  mi4_pkg::stat_t       stat_i,
  input  mi4_pkg::elem_t       result_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_row_o,
  output logic [1:0]           out_col_o,
  output mi4_pkg::elem_t       out_value_o,
  output logic                 singular_o,
  output logic                 last_o
);

  typedef enum logic [2:0] {
    StLoad, StMinor, StDet, StCof, StDivStart, StDiv, StOut
  } state_e;

  state_e state_q;
  logic [3:0] load_q, sel_q, cof_q;
  logic [2:0] step_q;
  logic       phase_q;
  logic       fire;

  assign in_ready_o = (state_q == StLoad);
  assign fire       = in_valid_i && in_ready_o;
  assign wr_en_o    = fire;
  assign wr_idx_o   = load_q;

  always_comb begin
    cmd_o.op      = mi4_pkg::OpNone;
    cmd_o.sel     = sel_q;
    cmd_o.cof_idx = cof_q;
    cmd_o.phase   = phase_q;
    cmd_o.step    = step_q;
    unique case (state_q)
      StMinor:    cmd_o.op = mi4_pkg::OpMinor;
      StDet:      cmd_o.op = mi4_pkg::OpDet;
      StCof:      cmd_o.op = mi4_pkg::OpCof;
      StDivStart: cmd_o.op = mi4_pkg::OpDivStart;
      StDiv:      cmd_o.op = stat_i.div_done ? mi4_pkg::OpNone : mi4_pkg::OpDivStep;
      default:    cmd_o.op = mi4_pkg::OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      load_q      <= '0;
      sel_q       <= '0;
      cof_q       <= '0;
      step_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_o <= 1'b0;
      out_row_o   <= '0;
      out_col_o   <= '0;
      out_value_o <= '0;
      singular_o  <= 1'b0;
      last_o      <= 1'b0;
    end else begin
      unique case (state_q)
        StLoad: begin
          if (fire) begin
            load_q <= load_q + 1'b1;
            if (load_q == 4'd15) begin
              state_q <= StMinor;
              sel_q   <= '0;
              step_q  <= '0;
              phase_q <= 1'b0;
            end
          end
        end
        StMinor: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            sel_q <= sel_q + 1'b1;
            if (sel_q == 4'd11) begin
              sel_q   <= '0;
              state_q <= StDet;
            end
          end
        end
        StDet: begin
          step_q <= step_q + 1'b1;
          if (step_q == mi4_pkg::MulApply) begin
            step_q <= '0;
            sel_q  <= sel_q + 1'b1;
            if (sel_q == 4'd5) begin
              sel_q   <= '0;
              cof_q   <= '0;
              state_q <= StCof;
            end
          end
        end
        StCof: begin
          step_q <= step_q + 1'b1;
          if (step_q == mi4_pkg::MulApply) begin
            step_q <= '0;
            sel_q  <= sel_q + 1'b1;
            if (sel_q == 4'd2) begin
              sel_q   <= '0;
              state_q <= stat_i.det_zero ? StOut : StDivStart;
              if (stat_i.det_zero) begin
                out_valid_o <= 1'b1;
                out_row_o   <= cof_q[3:2];
                out_col_o   <= cof_q[1:0];
                out_value_o <= '0;
                singular_o  <= 1'b1;
                last_o      <= (cof_q == 4'd15);
              end
            end
          end
        end
        StDivStart: state_q <= StDiv;
        StDiv: begin
          if (stat_i.div_done) begin
            out_valid_o <= 1'b1;
            out_row_o   <= cof_q[3:2];
            out_col_o   <= cof_q[1:0];
            out_value_o <= result_i;
            singular_o  <= 1'b0;
            last_o      <= (cof_q == 4'd15);
            state_q     <= StOut;
          end
        end
        default: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            cof_q       <= cof_q + 1'b1;
            state_q     <= (cof_q == 4'd15) ? StLoad : StCof;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/matrix_inverse_4x4_unit.sv -----
// matrix_inverse_4x4_unit: top level of the 4x4 fixed-point matrix inverse.
// Depends on mi4_pkg, mi4_ctrl and mi4_datapath.
//
//  Channel | Dir | Bus                       | Fields (low bit up)
//  s_axis  | in  | tdata[31:0]               | element_value
//  m_axis  | out | tdata[39:0], tuser, tlast | out_row, out_col, out_value; singular; last_result
//
// Sequence: 16 load transfers, then 12 minors of two products each, the determinant
// (six terms of four 32x32 limb products and one accumulate), and per result three
// cofactor terms, then, unless the determinant is zero, a divider load, 133 divider
// steps (one quotient bit per cycle) and a capture, and last the output transfer.
// The divider loop sets the rate. Reset is asynchronous, active low, and clears
// the load count and sequencer. A stalled output holds the sequencer; input is
// taken only while loading.
module matrix_inverse_4x4_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // element_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_row[1:0], out_col[3:2], out_value[35:4], zero pad
  output logic        m_axis_tuser,   // singular
  output logic        m_axis_tlast    // last_result
);

  logic               wr_en;
  logic [3:0]         wr_idx;
  mi4_pkg::cmd_t      cmd;
  mi4_pkg::stat_t     stat;
  mi4_pkg::elem_t     result;
  logic [1:0]         out_row, out_col;
  mi4_pkg::elem_t     out_value;

  // Sequence loads, arithmetic steps and the output register.
  mi4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .result_i    (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_value_o (out_value),
    .singular_o  (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  // Hold the matrix, accumulate minors and cofactors, divide.
  mi4_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (s_axis_tdata),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .result_o  (result)
  );

  assign m_axis_tdata = {4'b0, out_value, out_col, out_row};

endmodule

// ----- rtl/mi4_checker.sv -----
// mi4_checker: port-level assertions for matrix_inverse_4x4_unit, bound below.
// Depends only on the top level's ports.
module mi4_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Never load while results are pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input ready during output");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");

  // Singular results carry zero value.
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[35:4] == 32'd0)
    else $error("singular value not zero");

  // Last flag only on row 3 column 3.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'hF)
    else $error("tlast misplaced");

endmodule

bind matrix_inverse_4x4_unit mi4_checker u_mi4_checker (.*);

// ----- tb/matrix_inverse_4x4_unit_checker.sv -----
`timescale 1ns / 1ps
// matrix_inverse_4x4_unit_checker: watches both stream channels of the 4x4 inverse unit,
// predicts each inverse element from the loaded matrix and compares; depends on nothing.
module matrix_inverse_4x4_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          pending_o,
  output int          fail_count_o
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        singular;
    logic        last;
  } inv_elem_t;

  inv_elem_t   inverse_q[$];
  logic [31:0] loaded[16];
  wide_t       mat_w[16];
  logic [3:0]  elem_idx;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  // 3x3 determinant of the matrix with row sr and column sc struck out.
  function automatic wide_t det3(input int sr, input int sc);
    wide_t b[9];
    int k;
    k = 0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (r != sr && c != sc) begin
          b[k] = mat_w[r*4+c];
          k++;
        end
    return b[0]*(b[4]*b[8]-b[5]*b[7]) - b[1]*(b[3]*b[8]-b[5]*b[6])
         + b[2]*(b[3]*b[7]-b[4]*b[6]);
  endfunction

  function automatic wide_t cofactor(input int r, input int c);
    wide_t m;
    m = det3(r, c);
    return ((r + c) % 2 == 1) ? -m : m;
  endfunction

  // round(C * 2^32 / D), ties away from zero, saturated to 32 bits.
  function automatic logic [31:0] scaled_quotient(input wide_t cof, input wide_t det);
    wide_t n, d, q;
    logic  neg;
    neg = (cof < 0) != (det < 0);
    n = (cof < 0) ? -cof : cof;
    d = (det < 0) ? -det : det;
    q = ((n <<< 33) + d) / (d <<< 1);
    if (!neg) return (q > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q > 64'sh8000_0000) q = 64'sh8000_0000;
    return 32'(-q);
  endfunction

  task automatic predict_inverse();
    wide_t     det;
    inv_elem_t e;
    for (int i = 0; i < 16; i++) mat_w[i] = wide_t'($signed(loaded[i]));
    det = 0;
    for (int c = 0; c < 4; c++) det += mat_w[c] * cofactor(0, c);
    for (int i = 0; i < 16; i++) begin
      e.row = 2'(i / 4);
      e.col = 2'(i % 4);
      e.singular = (det == 0);
      // inverse[r][c] is the cofactor of element (c, r) over the determinant
      e.value = e.singular ? 32'h0 : scaled_quotient(cofactor(i % 4, i / 4), det);
      e.last = (i == 15);
      inverse_q.push_back(e);
    end
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    inv_elem_t e;
    if (!rst_ni) begin
      elem_idx <= 4'd0;
      inverse_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          e = inverse_q.pop_front();
          if (m_axis_tdata[1:0] !== e.row)
            report($sformatf("row %0d, want %0d", m_axis_tdata[1:0], e.row));
          if (m_axis_tdata[3:2] !== e.col)
            report($sformatf("col %0d, want %0d", m_axis_tdata[3:2], e.col));
          if (m_axis_tdata[35:4] !== e.value)
            report($sformatf("value %h, want %h (row %0d col %0d)",
                             m_axis_tdata[35:4], e.value, e.row, e.col));
          if (m_axis_tdata[39:36] !== 4'h0) report("nonzero pad bits");
          if (m_axis_tuser !== e.singular)
            report($sformatf("singular %b, want %b", m_axis_tuser, e.singular));
          if (m_axis_tlast !== e.last)
            report($sformatf("last %b, want %b", m_axis_tlast, e.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        loaded[elem_idx] = s_axis_tdata;
        if (elem_idx == 4'd15) predict_inverse();
        elem_idx <= elem_idx + 4'd1;
      end
    end
    pending_o = inverse_q.size();
  end

endmodule

// ----- tb/matrix_inverse_4x4_unit_test.sv -----
`timescale 1ns / 1ps
// matrix_inverse_4x4_unit_test: stimulus and verdict for matrix_inverse_4x4_unit.
// Depends on the unit's RTL and on matrix_inverse_4x4_unit_checker.
module matrix_inverse_4x4_unit_test;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'h0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  int          pending, fail_count;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [31:0] mat[16];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix_inverse_4x4_unit dut (.*);

  matrix_inverse_4x4_unit_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // Enter and leave at a falling edge; hold valid until the transfer.
  task automatic send_elem(input logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_matrix();
    for (int i = 0; i < 16; i++) send_elem(mat[i]);
  endtask

  function automatic logic [31:0] small_q16();
    return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;  // about -4.0 .. 4.0
  endfunction

  // Fill mat with one random matrix of a random flavor.
  task automatic make_random_matrix();
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0, 1:    mat[i] = $urandom();
        2, 3:    mat[i] = small_q16();
        default: mat[i] = (i % 5 == 0) ? ONE_Q16 * $urandom_range(1, 8) + small_q16() / 8
                                       : small_q16() / 4;
      endcase
    end
    // duplicate a row to force an exactly zero determinant
    if (kind == 4 || kind == 5)
      for (int c = 0; c < 4; c++) mat[12 + c] = mat[4 + c];
    // sprinkle extreme elements now and then
    if ($urandom_range(0, 3) == 0) mat[$urandom_range(0, 15)] = 32'h8000_0000;
    if ($urandom_range(0, 3) == 0) mat[$urandom_range(0, 15)] = 32'h7FFF_FFFF;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Regular matrix with extreme diagonal elements; small ones saturate on inversion.
    for (int i = 0; i < 16; i++) mat[i] = 32'h0;
    mat[0] = 32'h8000_0000; mat[5] = 32'h7FFF_FFFF; mat[10] = 32'h0000_0001;
    mat[15] = 32'hFFFF_FFFF; mat[3] = ONE_Q16;
    send_matrix();
    // Zero matrix: singular.
    for (int i = 0; i < 16; i++) mat[i] = 32'h0;
    send_matrix();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 23 : 0;
      for (int m = 0; m < 10; m++) begin
        make_random_matrix();
        send_matrix();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
